FILE: src/twt_pkg.sv
package twt_pkg;

  localparam int MAX_WORD_LEN_DEF = 32;
  localparam int OFFSET_BITS_DEF  = 16;

  // character count used for the length check, saturating
  localparam int LEN_W   = 7;
  localparam int LEN_SAT = 127;

  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int MINLEN_W = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CASE_SENS = 2'd0,
    REG_MIN_LEN   = 2'd1
  } cfg_reg_t;

  localparam logic [MINLEN_W-1:0] MIN_LEN_RST = 6'd2;

  function automatic logic is_sep(input logic [BYTE_W-1:0] b);
    logic r;
    unique case (b)
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
      8'h2c, 8'h2e, 8'h21, 8'h3f, 8'h3b, 8'h3a,
      8'h22, 8'h27, 8'h28, 8'h29, 8'h5b, 8'h5d,
      8'h7b, 8'h7d: r = 1'b1;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: src/twt_fifo.sv
module twt_fifo import twt_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         not_empty,
  output logic         full
);

  // two entries, one per buffer bank
  logic [W-1:0] ent_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   cnt_r;

  assign dout      = ent_r[rptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= din;
    end
  end

endmodule

FILE: src/twt_front.sv
module twt_front import twt_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
  localparam int AW = $clog2(MAX_WORD_LEN),
  localparam int KW = $clog2(MAX_WORD_LEN + 1),
  localparam int DW = 1 + 3 * OFFSET_BITS + KW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,
  input  logic                  in_tlast,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [DW-1:0]         q_din,
  output logic                  wr_en,
  output logic [AW:0]           wr_addr,
  output logic [BYTE_W-1:0]     wr_data
);

  typedef struct packed {
    logic                   bank;
    logic [OFFSET_BITS-1:0] start_ofs;
    logic [OFFSET_BITS-1:0] end_ofs;
    logic [OFFSET_BITS-1:0] idx;
    logic [KW-1:0]          kept;
    logic                   ovf;
  } desc_t;

  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_WORD_LEN);
  localparam logic [LEN_W-1:0] SATL = LEN_W'(LEN_SAT);

  logic                   case_r;
  logic [MINLEN_W-1:0]    minlen_r;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  logic [OFFSET_BITS-1:0] idx_r, idx_nxt;
  logic                   in_word_r, in_word_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   bank_r, bank_nxt;

  logic                   accept, is_zero, is_delim, is_chr;
  logic [LEN_W-1:0]       len_cur, len_new, fin_len;
  logic                   ovf_cur, ovf_new;
  logic [OFFSET_BITS-1:0] start_cur, ofs_inc, fin_end;
  logic                   fin, keep;
  desc_t                  desc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign is_zero  = (in_tdata == '0);
  assign is_delim = is_sep(in_tdata);
  assign is_chr   = !is_zero && !is_delim;

  assign len_cur   = in_word_r ? len_r : '0;
  assign ovf_cur   = in_word_r && ovf_r;
  assign start_cur = in_word_r ? start_r : ofs_r;
  assign len_new   = (len_cur < SATL) ? len_cur + 1'b1 : len_cur;
  assign ovf_new   = ovf_cur || (len_cur >= MAXL);
  assign ofs_inc   = (ofs_r == '1) ? ofs_r : ofs_r + 1'b1;

  // a word ends at a delimiter or zero byte, or after its last char at end of text
  assign fin     = accept && !stopped_r &&
                   ((in_word_r && !is_chr) || (is_chr && in_tlast));
  assign fin_len = is_chr ? len_new : len_r;
  assign fin_end = is_chr ? ofs_inc : ofs_r;
  assign keep    = (minlen_r == '0) || (fin_len >= {1'b0, minlen_r});
  assign q_push  = fin && keep;

  always_comb begin
    desc.bank      = bank_r;
    desc.start_ofs = start_cur;
    desc.end_ofs   = fin_end;
    desc.idx       = idx_r;
    desc.kept      = KW'((fin_len < MAXL) ? fin_len : MAXL);
    desc.ovf       = is_chr ? ovf_new : ovf_r;
  end
  assign q_din = desc;

  assign wr_en   = accept && !stopped_r && is_chr && (len_cur < MAXL);
  assign wr_addr = {bank_r, len_cur[AW-1:0]};
  assign wr_data = case_r ? in_tdata : fold_lower(in_tdata);

  always_comb begin
    len_nxt     = len_r;
    start_nxt   = start_r;
    ofs_nxt     = ofs_r;
    idx_nxt     = idx_r;
    in_word_nxt = in_word_r;
    ovf_nxt     = ovf_r;
    stopped_nxt = stopped_r;
    bank_nxt    = bank_r;
    if (accept && !stopped_r) begin
      priority if (is_zero) begin
        in_word_nxt = 1'b0;
        stopped_nxt = 1'b1;
      end else if (is_delim) begin
        in_word_nxt = 1'b0;
        ofs_nxt     = ofs_inc;
      end else begin
        in_word_nxt = 1'b1;
        start_nxt   = start_cur;
        len_nxt     = len_new;
        ovf_nxt     = ovf_new;
        ofs_nxt     = ofs_inc;
      end
      if (q_push) begin
        idx_nxt  = (idx_r == '1) ? idx_r : idx_r + 1'b1;
        bank_nxt = ~bank_r;
      end
    end
    if (accept && in_tlast) begin
      ofs_nxt     = '0;
      idx_nxt     = '0;
      in_word_nxt = 1'b0;
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_r    <= 1'b0;
      minlen_r  <= MIN_LEN_RST;
      len_r     <= '0;
      start_r   <= '0;
      ofs_r     <= '0;
      idx_r     <= '0;
      in_word_r <= 1'b0;
      ovf_r     <= 1'b0;
      stopped_r <= 1'b0;
      bank_r    <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      start_r   <= start_nxt;
      ofs_r     <= ofs_nxt;
      idx_r     <= idx_nxt;
      in_word_r <= in_word_nxt;
      ovf_r     <= ovf_nxt;
      stopped_r <= stopped_nxt;
      bank_r    <= bank_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_CASE_SENS) begin
          case_r <= cfg_data[0];
        end else if (cfg_index == REG_MIN_LEN) begin
          minlen_r <= cfg_data[MINLEN_W-1:0];
        end
      end
    end
  end

endmodule

FILE: src/twt_back.sv
module twt_back import twt_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
  localparam int AW = $clog2(MAX_WORD_LEN),
  localparam int KW = $clog2(MAX_WORD_LEN + 1),
  localparam int DW = 1 + 3 * OFFSET_BITS + KW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [DW-1:0]         q_dout,
  output logic                  q_pop,
  input  logic                  wr_en,
  input  logic [AW:0]           wr_addr,
  input  logic [BYTE_W-1:0]     wr_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [4*FIELD_W-9:0]  out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  typedef struct packed {
    logic                   bank;
    logic [OFFSET_BITS-1:0] start_ofs;
    logic [OFFSET_BITS-1:0] end_ofs;
    logic [OFFSET_BITS-1:0] idx;
    logic [KW-1:0]          kept;
    logic                   ovf;
  } desc_t;

  // two banks of word characters, the front fills one while the other drains
  logic [BYTE_W-1:0] char_mem [2**(AW+1)];

  desc_t             head;
  logic [KW-1:0]     rd_ptr_r;
  logic              pend_r, pend_last_r;
  desc_t             pend_meta_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              out_valid_r, out_last_r, out_trunc_r;
  logic [4*FIELD_W-9:0] out_data_r;

  logic              load, issue, last_rd;
  logic [OFFSET_BITS+FIELD_W-1:0] start_ext, end_ext, idx_ext;

  assign head    = desc_t'(q_dout);
  assign load    = pend_r && (!out_valid_r || out_tready);
  assign issue   = q_valid && (!pend_r || load);
  assign last_rd = (rd_ptr_r + KW'(1)) == head.kept;
  assign q_pop   = issue && last_rd;

  // results carry the low bits of offsets and index
  assign start_ext = {{FIELD_W{1'b0}}, pend_meta_r.start_ofs};
  assign end_ext   = {{FIELD_W{1'b0}}, pend_meta_r.end_ofs};
  assign idx_ext   = {{FIELD_W{1'b0}}, pend_meta_r.idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r   <= char_mem[{head.bank, rd_ptr_r[AW-1:0]}];
      pend_meta_r <= head;
      pend_last_r <= last_rd;
    end
    if (load) begin
      out_data_r  <= {idx_ext[FIELD_W-1:0], end_ext[FIELD_W-1:0],
                      start_ext[FIELD_W-1:0], rd_data_r};
      out_last_r  <= pend_last_r;
      out_trunc_r <= pend_meta_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        rd_ptr_r <= last_rd ? '0 : rd_ptr_r + KW'(1);
      end
      if (issue) begin
        pend_r <= 1'b1;
      end else if (load) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_trunc_r;

endmodule

FILE: src/text_word_tokenizer_core.sv
// word tokenizer: text bytes in, word characters out
// in_*: one text byte per transaction, in_tlast marks the final byte of a text.
//   whitespace and punctuation end a word, a zero byte ends the text early and
//   later bytes are ignored until in_tlast.
// out_*: one character per transaction, with start/end offsets and word index;
//   out_tlast flags the word's final character, out_tuser flags a truncated word.
// cfg_*: register writes (0 keep-case flag, 1 min_length), always ready,
//   write only while the block is idle.
// throughput: one input byte per cycle; in_tready drops only while two finished
//   words wait in the descriptor queue (both character banks busy).
// output path: the first character of a word goes through the registered buffer read
//   and then the output register after the byte that ends it; after that one character
//   per cycle while out_tready stays high.
// a stalled out_tready holds the current result; the front keeps taking bytes
//   until the queue fills.
// reset clears counters, queue and output valid; no clearing pass.
module text_word_tokenizer_core import twt_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // text_byte
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // word_char, start_ofs, word_end, word_index
  output logic                  out_tlast,  // last_char
  output logic                  out_tuser,  // truncated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WORD_LEN);
  localparam int KW = $clog2(MAX_WORD_LEN + 1);
  localparam int DW = 1 + 3 * OFFSET_BITS + KW + 1;

  logic              q_push, q_pop, q_full, q_valid;
  logic [DW-1:0]     q_din, q_dout;
  logic              wr_en;
  logic [AW:0]       wr_addr;
  logic [BYTE_W-1:0] wr_data;

  assign cfg_ready = 1'b1;

  twt_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  twt_fifo #(
    .W (DW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_valid),
    .full      (q_full)
  );

  twt_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: src/twt_checker.sv
module twt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [55:0]           out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // characters of one word share start, end, index and truncation flag
  a_word_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> $stable(out_tdata[55:8]) && $stable(out_tuser))
    else $error("word fields changed inside a word");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // queue is empty after reset so input is open
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind text_word_tokenizer_core twt_checker u_twt_checker (.*);

FILE: tb/text_word_tokenizer_core_test.sv
`timescale 1ns / 1ps

import twt_pkg::*;

localparam logic [7:0] NUL_BYTE = 8'h00;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

typedef struct packed {
  logic [7:0]  ch;
  logic [15:0] first;
  logic [15:0] after;
  logic [15:0] ordinal;
  logic        last;
  logic        cut;
} word_char_t;

class word_scoreboard;
  logic [7:0]  word_bytes [MAX_WORD_LEN_DEF];
  int unsigned char_count;
  logic [15:0] word_first;
  logic [15:0] text_pos;
  logic [15:0] word_no;
  bit          in_word;
  bit          spilled;
  bit          halted;
  bit          keep_case;
  logic [5:0]  min_len;
  word_char_t  pending[$];
  int          errors;

  function new();
    char_count = 0;
    word_first = '0;
    text_pos   = '0;
    word_no    = '0;
    in_word    = 0;
    spilled    = 0;
    halted     = 0;
    keep_case  = 0;
    min_len    = MIN_LEN_RST;
    errors     = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [5:0] val);
    if (idx == REG_CASE_SENS) begin
      keep_case = val[0];
    end else if (idx == REG_MIN_LEN) begin
      min_len = val;
    end
  endfunction

  function bit is_delim(logic [7:0] b);
    case (b)
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
      ",", ".", "!", "?", ";", ":", 8'h22, 8'h27,
      "(", ")", "[", "]", "{", "}": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function logic [15:0] bump(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  // queues the characters of the finished word, if it passes the length check
  function int close_word(logic [15:0] stop);
    int kept;
    word_char_t e;
    if (!in_word) return 0;
    in_word = 0;
    if (min_len != 0 && char_count < min_len) return 0;
    kept = (char_count < MAX_WORD_LEN_DEF) ? char_count : MAX_WORD_LEN_DEF;
    for (int i = 0; i < kept; i++) begin
      e.ch      = word_bytes[i];
      e.first   = word_first;
      e.after   = stop;
      e.ordinal = word_no;
      e.last    = (i == kept - 1);
      e.cut     = spilled;
      pending.push_back(e);
    end
    word_no = bump(word_no);
    return kept;
  endfunction

  function void restart_text();
    text_pos = '0;
    word_no  = '0;
    in_word  = 0;
    halted   = 0;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    int made;
    logic [7:0] c;
    made = 0;
    c = b;
    if (halted) begin
      if (last) restart_text();
      return;
    end
    if (b == NUL_BYTE) begin
      made = close_word(text_pos);
      halted = 1;
    end else if (is_delim(b)) begin
      made = close_word(text_pos);
      text_pos = bump(text_pos);
    end else begin
      if (!in_word) begin
        in_word    = 1;
        word_first = text_pos;
        char_count = 0;
        spilled    = 0;
      end
      if (!keep_case && c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
      if (char_count < MAX_WORD_LEN_DEF) word_bytes[char_count] = c;
      else spilled = 1;
      if (char_count < LEN_SAT) char_count++;
      text_pos = bump(text_pos);
    end
    if (last) begin
      if (made == 0) made = close_word(text_pos);
      restart_text();
    end
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task check_char(logic [55:0] d, logic l, logic u);
    word_char_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected character %02h", d[7:0]));
      return;
    end
    e = pending.pop_front();
    if (d[7:0] !== e.ch)
      report($sformatf("word_char %02h, want %02h", d[7:0], e.ch));
    if (d[23:8] !== e.first)
      report($sformatf("start_ofs %0d, want %0d", d[23:8], e.first));
    if (d[39:24] !== e.after)
      report($sformatf("word_end %0d, want %0d", d[39:24], e.after));
    if (d[55:40] !== e.ordinal)
      report($sformatf("word_index %0d, want %0d", d[55:40], e.ordinal));
    if (l !== e.last)
      report($sformatf("last_char %b, want %b", l, e.last));
    if (u !== e.cut)
      report($sformatf("truncated %b, want %b", u, e.cut));
  endtask
endclass

module text_word_tokenizer_core_test;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 100;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_CASE_SENS;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [55:0]           out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_ready;

  word_scoreboard sb = new();
  bit             calm = 0;
  int unsigned    out_hold = 0;
  int             random_items = 0;

  text_word_tokenizer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] delim_byte();
    case ($urandom_range(0, 19))
      0:  return 8'h20;
      1:  return 8'h09;
      2:  return 8'h0a;
      3:  return 8'h0b;
      4:  return 8'h0c;
      5:  return 8'h0d;
      6:  return ",";
      7:  return ".";
      8:  return "!";
      9:  return "?";
      10: return ";";
      11: return ":";
      12: return 8'h22;
      13: return 8'h27;
      14: return "(";
      15: return ")";
      16: return "[";
      17: return "]";
      18: return "{";
      default: return "}";
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 75) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 85) return 8'h30 + 8'($urandom_range(0, 9));
    // anything nonzero, high bytes included; may land on a delimiter
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [5:0] pick_min_len();
    case ($urandom_range(0, 5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd3;
      4: return 6'd32;
      default: return 6'($urandom_range(0, 32));
    endcase
  endfunction

  // check every character transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_char(out_tdata, out_tlast, out_tuser);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_tready <= 1'b0;
      out_hold = out_hold - 1;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      out_hold = gap_len();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned idle;
    idle = calm ? 0 : gap_len();
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
  endtask

  task automatic play_str(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
  endtask

  task automatic play(ref logic [7:0] text_q[$]);
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // let all expected characters out, then give dropped words time to clear
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic keep, input logic [5:0] min_len);
    logic [5:0] case_val;
    logic [5:0] spare_val;
    case_val  = 6'($urandom & 32'h3e) | {5'd0, keep};
    spare_val = 6'($urandom_range(0, 63));
    write_reg(REG_CASE_SENS, case_val);
    write_reg(REG_MIN_LEN, min_len);
    // unmapped indexes must leave both registers alone
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, spare_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text();
    logic [7:0] text_q[$];
    int n_words;
    int wlen;
    int live;
    n_words = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) text_q.push_back(delim_byte());
    for (int w = 0; w < n_words; w++) begin
      wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 8);
      for (int k = 0; k < wlen; k++) text_q.push_back(word_byte());
      if (w != n_words - 1 || $urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 2)) text_q.push_back(delim_byte());
    end
    live = text_q.size();
    if ($urandom_range(0, 9) == 0) begin
      live = $urandom_range(0, text_q.size() - 1);
      text_q.insert(live, NUL_BYTE);
      live++;
    end
    if ($urandom_range(0, 19) == 0) begin
      // separators only, no word at all
      text_q.delete();
      repeat ($urandom_range(1, 4)) text_q.push_back(delim_byte());
      live = text_q.size();
    end
    play(text_q);
    random_items += live;
  endtask

  initial begin
    logic [7:0] text_q[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: folding on, minimum length two
    play_str("AZ@", 1'b0);
    send_byte(8'h60, 1'b0);
    play_str("az ", 1'b0);
    play_str("x)", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    play_str("QR", 1'b0);
    send_byte(NUL_BYTE, 1'b0);
    play_str("zz", 1'b0);
    send_byte("k", 1'b1);
    send_byte(NUL_BYTE, 1'b1);
    settle();
    configure(1'b1, 6'd0);
    play_str("A\t ", 1'b1);
    // folding switched on in the middle of a word
    play_str("Ab", 1'b0);
    settle();
    configure(1'b0, 6'd0);
    play_str("Cd.", 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        settle();
        configure($urandom_range(0, 1), pick_min_len());
      end
      send_text();
    end

    // words around and far beyond the buffer size
    calm = 0;
    settle();
    configure($urandom_range(0, 1), 6'd32);
    text_q.delete();
    for (int w = 0; w < 3; w++) begin
      repeat (31 + w) text_q.push_back(word_byte());
      text_q.push_back(delim_byte());
    end
    repeat ($urandom_range(128, 135)) text_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
    play(text_q);

    settle();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
